// ----- rtl/core/ultrasonic_frame_obstacle_guard_unit_defines.svh -----
// Assertion macros for the ultrasonic frame obstacle guard.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ULTRASONIC_FRAME_OBSTACLE_GUARD_UNIT_DEFINES_SVH
`define ULTRASONIC_FRAME_OBSTACLE_GUARD_UNIT_DEFINES_SVH

// same-cycle implication
`define UFOG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UFOG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ufog_pkg.sv -----
// Shared types and constants of the ultrasonic frame obstacle guard.
// No dependencies; imported by every module of the block.
package ufog_pkg;

  localparam logic [7:0] HDR_FIRST      = 8'hAA;
  localparam logic [7:0] HDR_SECOND     = 8'h55;
  localparam logic [7:0] DIR_FRONT_CODE = 8'h5A;
  localparam logic [7:0] DIR_REAR_CODE  = 8'hA5;

  localparam logic [3:0] HIT_MAX = 4'hF;

  // frame status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_HDR1 = 3'd1;
  localparam logic [2:0] ST_HDR2 = 3'd2;
  localparam logic [2:0] ST_DIR  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;

  // byte positions within a frame
  localparam logic [2:0] POS_HDR1 = 3'd0;
  localparam logic [2:0] POS_HDR2 = 3'd1;
  localparam logic [2:0] POS_DIR  = 3'd2;
  localparam logic [2:0] POS_D0   = 3'd3;
  localparam logic [2:0] POS_D3   = 3'd6;
  localparam logic [2:0] POS_SUM  = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_DISTANCE_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_DETECT_ENABLE    = 2'd1;
  localparam logic [1:0] CFG_HIT_COUNT_NEEDED = 2'd2;

  localparam logic [7:0] LIMIT_RESET  = 8'd30;
  localparam logic       ENABLE_RESET = 1'b1;
  localparam logic [3:0] HIT_RESET    = 4'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [3:0][7:0] dist_set_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       port;
    logic [1:0] travel_dir;
  } in_item_t;

  typedef struct packed {
    logic [2:0] frame_status;
    logic       result_port;
    logic       frame_dir;
    logic [7:0] dist_first;
    logic [7:0] dist_second;
    logic [7:0] dist_third;
    logic [7:0] dist_fourth;
    logic       obstacle_flag;
    logic       indicator_toggle;
    logic       stop_request;
  } out_item_t;

  typedef struct packed {
    logic [7:0] distance_limit;
    logic       detect_enable;
    logic [3:0] hit_count_needed;
  } cfg_t;

  // one parsed frame, handed from the parser to the evaluator
  typedef struct packed {
    logic [2:0] status;
    logic       port;
    logic       dir;
    dist_set_t  dists;
    logic [1:0] travel_dir;
  } frame_rec_t;

endpackage

// ----- rtl/core/ufog_front.sv -----
// Frame parser: tracks byte position, header/direction checks and checksum.
// Depends on ufog_pkg; emits one frame record per eighth byte.
module ufog_front
  import ufog_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   item,
  input  logic       accept,
  output logic       push,
  output frame_rec_t rec
);

  logic [2:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [2:0] err_r, err_nxt;
  logic       dir_r, dir_nxt;
  dist_set_t  dist_r, dist_nxt;
  logic [2:0] pos;
  logic [2:0] dist_off;

  always_comb begin
    pos      = item.frame_start ? POS_HDR1 : pos_r;
    dist_off = pos - POS_D0;
    pos_nxt  = pos + 3'd1;
    sum_nxt  = sum_r;
    err_nxt  = err_r;
    dir_nxt  = dir_r;
    dist_nxt = dist_r;
    case (pos)
      POS_HDR1: begin
        sum_nxt = '0;
        err_nxt = (item.frame_byte != HDR_FIRST) ? ST_HDR1 : ST_OK;
      end
      POS_HDR2: begin
        if (err_r == ST_OK && item.frame_byte != HDR_SECOND) err_nxt = ST_HDR2;
      end
      POS_DIR: begin
        if (err_r == ST_OK) begin
          if (item.frame_byte == DIR_FRONT_CODE) dir_nxt = 1'b0;
          else if (item.frame_byte == DIR_REAR_CODE) dir_nxt = 1'b1;
          else err_nxt = ST_DIR;
        end
        sum_nxt = item.frame_byte;
      end
      POS_SUM: ;
      default: begin
        // distance bytes
        if (err_r == ST_OK) dist_nxt[dist_off[1:0]] = item.frame_byte;
        sum_nxt = sum_r + item.frame_byte;
      end
    endcase
  end

  assign push           = accept && (pos == POS_SUM);
  assign rec.status     = (err_r != ST_OK) ? err_r :
                          ((sum_r != item.frame_byte) ? ST_SUM : ST_OK);
  assign rec.port       = item.port;
  assign rec.dir        = dir_r;
  assign rec.dists      = dist_r;
  assign rec.travel_dir = item.travel_dir;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR1;
      sum_r <= '0;
      err_r <= ST_OK;
      dir_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      err_r <= err_nxt;
      dir_r <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) dist_r <= dist_nxt;
  end

endmodule

// ----- rtl/core/ufog_queue.sv -----
// Short frame-record queue between parser and evaluator.
// Depends on ufog_pkg for the record type and depth.
module ufog_queue
  import ufog_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t wr_rec,
  input  logic       pop,
  output logic       full,
  output logic       rd_valid,
  output frame_rec_t rd_rec
);

  frame_rec_t             entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_rec   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= wr_rec;
  end

endmodule

// ----- rtl/core/ufog_back.sv -----
// Obstacle evaluator: distance store, per-port hit counters and output register.
// Depends on ufog_pkg; consumes frame records from the queue.
module ufog_back
  import ufog_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       rec_valid,
  input  frame_rec_t rec,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  // only the port's own side set is ever compared: head/front and tail/rear
  dist_set_t  set_r  [2];
  logic [3:0] hit_r  [2];
  logic       flag_r [2];
  logic       out_valid_r;
  out_item_t  out_r, out_nxt;

  dist_set_t  eff;
  logic       store_ok, own_side, good, hit, toggle, flag_upd;
  logic [3:0] cnt_upd;

  assign pop = rec_valid && (!out_valid_r || !out_stall);

  always_comb begin
    store_ok = (rec.status == ST_OK) || (rec.status == ST_SUM);
    own_side = (rec.dir == rec.port);
    good     = (rec.status == ST_OK);
    eff      = (store_ok && own_side) ? rec.dists : set_r[rec.port];
    hit      = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (eff[k] < cfg.distance_limit) hit = 1'b1;
    end
    if (hit) cnt_upd = (hit_r[rec.port] == HIT_MAX) ? HIT_MAX : hit_r[rec.port] + 4'd1;
    else cnt_upd = '0;
    toggle   = (cnt_upd >= cfg.hit_count_needed);
    flag_upd = hit ? flag_r[rec.port] : 1'b0;
    if (toggle) flag_upd = 1'b1;

    out_nxt.frame_status     = rec.status;
    out_nxt.result_port      = rec.port;
    out_nxt.frame_dir        = store_ok ? rec.dir : 1'b0;
    out_nxt.dist_first       = store_ok ? rec.dists[0] : '0;
    out_nxt.dist_second      = store_ok ? rec.dists[1] : '0;
    out_nxt.dist_third       = store_ok ? rec.dists[2] : '0;
    out_nxt.dist_fourth      = store_ok ? rec.dists[3] : '0;
    out_nxt.obstacle_flag    = good ? flag_upd : flag_r[rec.port];
    out_nxt.indicator_toggle = good && toggle;
    out_nxt.stop_request     = good && cfg.detect_enable && flag_upd &&
                               (rec.travel_dir == {1'b0, rec.port});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        set_r[i]  <= '0;
        hit_r[i]  <= '0;
        flag_r[i] <= 1'b0;
      end
    end else if (pop) begin
      out_valid_r <= 1'b1;
      if (store_ok && own_side) set_r[rec.port] <= rec.dists;
      if (good) begin
        hit_r[rec.port]  <= cnt_upd;
        flag_r[rec.port] <= flag_upd;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/ultrasonic_frame_obstacle_guard_unit.sv -----
// Ultrasonic frame obstacle guard: takes one frame byte per clock and gives
// one status word per complete 8-byte frame once its checksum byte has passed
// the parser, the two-entry frame queue and the evaluator output register.
// The input stalls only when two finished frames wait behind a held output
// word; with the output free it sustains one byte per cycle indefinitely.
// Configuration is a write-only register port that is always ready.
`include "ultrasonic_frame_obstacle_guard_unit_defines.svh"

module ultrasonic_frame_obstacle_guard_unit
  import ufog_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  logic       in_accept, push, pop, q_full, q_valid;
  frame_rec_t push_rec, head_rec;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DISTANCE_LIMIT:   cfg_nxt.distance_limit   = cfg_data;
        CFG_DETECT_ENABLE:    cfg_nxt.detect_enable    = cfg_data[0];
        CFG_HIT_COUNT_NEEDED: cfg_nxt.hit_count_needed = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distance_limit   <= LIMIT_RESET;
      cfg_r.detect_enable    <= ENABLE_RESET;
      cfg_r.hit_count_needed <= HIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ufog_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (in_data),
    .accept (in_accept),
    .push   (push),
    .rec    (push_rec)
  );

  ufog_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_rec   (push_rec),
    .pop      (pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_rec   (head_rec)
  );

  ufog_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (q_valid),
    .rec       (head_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `UFOG_ASSERT_NOW(a_stop_needs_flag, out_valid && out_data.stop_request, out_data.obstacle_flag, "stop request without obstacle flag")
  `UFOG_ASSERT_NOW(a_bad_frame_quiet, out_valid && out_data.frame_status != ST_OK, !out_data.indicator_toggle && !out_data.stop_request, "bad frame raised toggle or stop")
  `UFOG_ASSERT_NOW(a_stall_only_behind_output, in_stall, out_valid, "input stalled with output register empty")
  `UFOG_ASSERT_NEXT(a_stall_releases, in_stall && !out_stall, !in_stall, "input stall held after output word taken")

endmodule
